### rtl/core/slruc_pkg.sv
// ----------------------------------------------------------------------------
// slruc_pkg: shared definitions for the LRU cache tag block
// Configuration types, register indexes, reset values and default sizes.
// ----------------------------------------------------------------------------
package slruc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned DefMaxSets   = 64;
  localparam int unsigned DefWays      = 8;
  localparam int unsigned DefAddrWidth = 64;
  localparam int unsigned DefCountWidth = 32;

  // Depth of the request queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Configuration port geometry.
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  // Register reset values.
  localparam logic [2:0] SetBitsRst   = 3'd1;
  localparam logic [4:0] BlockBitsRst = 5'd4;
  localparam logic [3:0] WaysRst      = 4'd8;

  // Access kinds carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  // Programmed configuration as seen by front and back.
  typedef struct packed {
    logic [2:0] set_bits;
    logic [4:0] block_bits;
    logic [3:0] ways;
  } cfg_t;

endpackage

### rtl/core/slruc_fifo.sv
// ----------------------------------------------------------------------------
// slruc_fifo: short request queue
// Small register queue that decouples the decode front from the set update.
// ----------------------------------------------------------------------------
module slruc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = slruc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/slruc_front.sv
// ----------------------------------------------------------------------------
// slruc_front: access decode
// Accepts access requests, splits the address into set and tag, and queues.
// ----------------------------------------------------------------------------
module slruc_front #(
  parameter int unsigned ADDR_WIDTH = slruc_pkg::DefAddrWidth,
  parameter int unsigned SET_W      = 6,
  parameter int unsigned TAG_W      = ADDR_WIDTH - 2
) (
  input  slruc_pkg::cfg_t        cfg_i,
  input  logic                   clearing_i,
  input  logic                   valid_i,
  output logic                   ready_i_o,
  input  logic [1:0]             cmd_i,
  input  logic [ADDR_WIDTH-1:0]  addr_i,
  input  logic                   queue_full_i,
  output logic                   push_o,
  output logic [TAG_W+SET_W:0]   entry_o
);

  logic [2:0]            set_bits_eff;
  logic [4:0]            block_bits_eff;
  logic [5:0]            tag_shift;
  logic [ADDR_WIDTH-1:0] after_block;
  logic [SET_W-1:0]      idx_mask;
  logic [SET_W-1:0]      set_idx;
  logic [TAG_W-1:0]      tag;
  logic                  is_modify;

  always_comb begin
    // Set bits below one count as one; the count is capped by the set store.
    if (cfg_i.set_bits == '0) begin
      set_bits_eff = 3'd1;
    end else if (32'(cfg_i.set_bits) > SET_W) begin
      set_bits_eff = 3'(SET_W);
    end else begin
      set_bits_eff = cfg_i.set_bits;
    end
    block_bits_eff = (cfg_i.block_bits == '0) ? 5'd1 : cfg_i.block_bits;
    tag_shift      = 6'(set_bits_eff) + 6'(block_bits_eff);
    after_block    = addr_i >> block_bits_eff;
    idx_mask       = ~({SET_W{1'b1}} << set_bits_eff);
    set_idx        = after_block[SET_W-1:0] & idx_mask;
    tag            = TAG_W'(addr_i >> tag_shift);
    is_modify      = (cmd_i == slruc_pkg::CMD_MODIFY);
  end

  // No request is taken while the set store is being cleared.
  assign ready_i_o = !queue_full_i && !clearing_i;
  assign push_o    = valid_i && ready_i_o;
  assign entry_o   = {tag, set_idx, is_modify};

endmodule

### rtl/core/slruc_back.sv
// ----------------------------------------------------------------------------
// slruc_back: set lookup and LRU update
// Reads one set, resolves hit, fill or eviction, writes it back, counts.
// ----------------------------------------------------------------------------
module slruc_back #(
  parameter int unsigned WAYS        = slruc_pkg::DefWays,
  parameter int unsigned COUNT_WIDTH = slruc_pkg::DefCountWidth,
  parameter int unsigned SET_W       = 6,
  parameter int unsigned TAG_W       = 62
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slruc_pkg::cfg_t       cfg_i,
  output logic                  clearing_o,
  input  logic                  queue_empty_i,
  input  logic [TAG_W+SET_W:0]  entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            out_flags_o,
  output logic [95:0]           out_totals_o
);

  localparam int unsigned Depth = 1 << SET_W;
  localparam int unsigned WayW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RankW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } state_e;

  state_e state_q;

  // Set store: one row per set, all ways side by side.
  logic [WAYS-1:0]             mem_valid [Depth];
  logic [WAYS-1:0][TAG_W-1:0]  mem_tag   [Depth];
  logic [WAYS-1:0][RankW-1:0]  mem_rank  [Depth];

  logic [WAYS-1:0]             rd_valid_q;
  logic [WAYS-1:0][TAG_W-1:0]  rd_tag_q;
  logic [WAYS-1:0][RankW-1:0]  rd_rank_q;

  logic [SET_W-1:0]       set_q;
  logic [TAG_W-1:0]       tag_q;
  logic                   modify_q;
  logic [SET_W-1:0]       clr_cnt_q;

  logic [COUNT_WIDTH-1:0] hits_q, hits_d;
  logic [COUNT_WIDTH-1:0] misses_q, misses_d;
  logic [COUNT_WIDTH-1:0] evicts_q, evicts_d;

  logic                   out_valid_q;
  logic [1:0]             out_flags_q;
  logic [95:0]            out_totals_q;

  logic [TAG_W-1:0]       head_tag;
  logic [SET_W-1:0]       head_set;
  logic                   head_modify;

  logic [3:0]             ways_eff;
  logic [WAYS-1:0]        used;
  logic                   hit, have_empty, have_lru, evicted;
  logic [WayW-1:0]        hit_way, empty_way, lru_way, sel_way;
  logic [RankW-1:0]       lru_rank;
  logic                   sel_valid;
  logic [WAYS-1:0]             new_valid;
  logic [WAYS-1:0][TAG_W-1:0]  new_tag;
  logic [WAYS-1:0][RankW-1:0]  new_rank;
  logic                   upd_go;
  logic                   mem_we;
  logic [SET_W-1:0]       mem_waddr;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign {head_tag, head_set, head_modify} = entry_i;

  assign clearing_o   = (state_q == S_CLEAR);
  assign pop_o        = (state_q == S_IDLE) && !queue_empty_i;
  assign upd_go       = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign out_flags_o  = out_flags_q;
  assign out_totals_o = out_totals_q;

  // Lookup, victim choice and recency update on the row that was read.
  always_comb begin
    ways_eff   = (cfg_i.ways == '0) ? 4'd1 : cfg_i.ways;
    hit        = 1'b0;
    hit_way    = '0;
    have_empty = 1'b0;
    empty_way  = '0;
    have_lru   = 1'b0;
    lru_rank   = '0;
    lru_way    = '0;
    for (int i = 0; i < WAYS; i++) begin
      used[i] = (32'(i) < 32'(ways_eff));
      if (used[i] && rd_valid_q[i]) begin
        if (!have_lru || rd_rank_q[i] > lru_rank) begin
          have_lru = 1'b1;
          lru_rank = rd_rank_q[i];
          lru_way  = WayW'(i);
        end
        if (rd_tag_q[i] == tag_q) begin
          hit     = 1'b1;
          hit_way = WayW'(i);
        end
      end else if (used[i] && !have_empty) begin
        have_empty = 1'b1;
        empty_way  = WayW'(i);
      end
    end

    evicted   = !hit && !have_empty;
    sel_way   = hit ? hit_way : (have_empty ? empty_way : lru_way);
    sel_valid = rd_valid_q[sel_way];

    new_valid = rd_valid_q;
    new_tag   = rd_tag_q;
    new_rank  = rd_rank_q;
    for (int i = 0; i < WAYS; i++) begin
      // Lines younger than the touched one age by one, saturating at the oldest rank.
      if ((WayW'(i) != sel_way) && used[i] && rd_valid_q[i] &&
          (!sel_valid || (rd_rank_q[i] < rd_rank_q[sel_way])) &&
          (rd_rank_q[i] != RankW'(WAYS - 1))) begin
        new_rank[i] = rd_rank_q[i] + 1'b1;
      end
    end
    new_rank[sel_way] = '0;
    if (!hit) begin
      new_valid[sel_way] = 1'b1;
      new_tag[sel_way]   = tag_q;
    end

    hits_d   = hit ? sat_inc(hits_q) : hits_q;
    if (modify_q) begin
      hits_d = sat_inc(hits_d);
    end
    misses_d = hit ? misses_q : sat_inc(misses_q);
    evicts_d = evicted ? sat_inc(evicts_q) : evicts_q;

    mem_we    = clearing_o || upd_go;
    mem_waddr = clearing_o ? clr_cnt_q : set_q;
  end

  // Set store ports: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_valid[mem_waddr] <= clearing_o ? '0 : new_valid;
    end
    if (upd_go) begin
      mem_tag[set_q]  <= new_tag;
      mem_rank[set_q] <= new_rank;
    end
    if (pop_o) begin
      rd_valid_q <= mem_valid[head_set];
      rd_tag_q   <= mem_tag[head_set];
      rd_rank_q  <= mem_rank[head_set];
    end
  end

  // Request payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      set_q    <= head_set;
      tag_q    <= head_tag;
      modify_q <= head_modify;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
      out_valid_q  <= 1'b0;
      out_flags_q  <= '0;
      out_totals_q <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == {SET_W{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!queue_empty_i) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (upd_go) begin
            state_q  <= S_IDLE;
            hits_q   <= hits_d;
            misses_q <= misses_d;
            evicts_q <= evicts_d;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (upd_go) begin
        out_valid_q  <= 1'b1;
        out_flags_q  <= {evicted, hit};
        out_totals_q <= {32'(64'(evicts_d)), 32'(64'(misses_d)), 32'(64'(hits_d))};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A finished update always leaves a result waiting.
  a_update_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |=> out_valid_q)
    else $error("update did not present a result");

  // Nothing leaves the queue while the set store is cleared.
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop_o)
    else $error("request taken during clearing pass");

  // A hit never evicts a line.
  a_hit_not_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_flags_q[0] && out_flags_q[1]))
    else $error("result marked both hit and eviction");

  // The hit and miss totals never go backward.
  a_hits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q)))
    else $error("running total decreased");

endmodule

### rtl/core/set_assoc_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags: set-associative cache tags with LRU replacement
// A request passes through the queue, is read from the set store in S_IDLE and is
// resolved and written back in S_UPDATE; the result is then registered. The back
// handles one request at a time and reads the next set only after the write-back.
// Reset: totals clear at once; a clearing pass over all 2**SET_W sets (64 by
// default) then zeroes all valid bits while s_axis_tready stays low.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags #(
  parameter int unsigned MAX_SETS    = slruc_pkg::DefMaxSets,
  parameter int unsigned WAYS        = slruc_pkg::DefWays,
  parameter int unsigned ADDR_WIDTH  = slruc_pkg::DefAddrWidth,
  parameter int unsigned COUNT_WIDTH = slruc_pkg::DefCountWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Access requests.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: address (ADDR_WIDTH bits), zero padded to whole bytes
  input  logic [((ADDR_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // tuser: cmd [1:0]
  input  logic [1:0]                        s_axis_tuser,
  // Results.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: hit_total [31:0], miss_total [63:32], evict_total [95:64]
  output logic [95:0]                       m_axis_tdata,
  // tuser: was_hit [0], was_evicted [1]
  output logic [1:0]                        m_axis_tuser,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slruc_pkg::ApbAddrW-1:0]    paddr,
  input  logic [slruc_pkg::ApbDataW-1:0]    pwdata,
  output logic [slruc_pkg::ApbDataW-1:0]    prdata,
  output logic                              pready
);

  // The largest usable set count is the largest power of two within MAX_SETS.
  localparam int unsigned SetW  = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned TagW  = ADDR_WIDTH - 2;
  localparam int unsigned EntryW = TagW + SetW + 1;

  slruc_pkg::cfg_t       cfg_q;
  logic                  cfg_wr;
  logic                  clearing;
  logic                  queue_full, queue_empty;
  logic                  push, pop;
  logic [EntryW-1:0]     push_entry, head_entry;

  // Registers are written in the access phase of an APB write; the port never
  // inserts wait states. Unused address space reads as zero and ignores writes.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits   <= slruc_pkg::SetBitsRst;
      cfg_q.block_bits <= slruc_pkg::BlockBitsRst;
      cfg_q.ways       <= slruc_pkg::WaysRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        slruc_pkg::REG_SET_BITS:   cfg_q.set_bits   <= pwdata[2:0];
        slruc_pkg::REG_BLOCK_BITS: cfg_q.block_bits <= pwdata[4:0];
        slruc_pkg::REG_WAYS:       cfg_q.ways       <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      slruc_pkg::REG_SET_BITS:   prdata = {29'd0, cfg_q.set_bits};
      slruc_pkg::REG_BLOCK_BITS: prdata = {27'd0, cfg_q.block_bits};
      slruc_pkg::REG_WAYS:       prdata = {28'd0, cfg_q.ways};
      default:                   prdata = '0;
    endcase
  end

  // Front: split each address into set index and tag, then queue the request.
  slruc_front #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .SET_W      (SetW),
    .TAG_W      (TagW)
  ) u_front (
    .cfg_i        (cfg_q),
    .clearing_i   (clearing),
    .valid_i      (s_axis_tvalid),
    .ready_i_o    (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .addr_i       (s_axis_tdata[ADDR_WIDTH-1:0]),
    .queue_full_i (queue_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // A short queue lets requests arrive while the back is busy or stalled.
  slruc_fifo #(
    .WIDTH (EntryW),
    .DEPTH (slruc_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .data_o  (head_entry),
    .empty_o (queue_empty)
  );

  // Back: one set at a time is read, resolved and written back. Since the
  // next request reads only after the write-back, no forwarding is needed.
  slruc_back #(
    .WAYS        (WAYS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .SET_W       (SetW),
    .TAG_W       (TagW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .clearing_o    (clearing),
    .queue_empty_i (queue_empty),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_flags_o   (m_axis_tuser),
    .out_totals_o  (m_axis_tdata)
  );

endmodule

### dv/tb_set_assoc_lru_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tags: self-checking bench for the LRU cache tag block
// Streams load, store and modify requests through the block under a series of
// register settings. A local tag/recency model predicts each result, and a
// monitor checks every field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_tags;

  // Geometry of the local model follows the block's default parameters.
  localparam int unsigned NumSets    = slruc_pkg::DefMaxSets;
  localparam int unsigned NumWays    = slruc_pkg::DefWays;
  localparam int unsigned MaxSetBits = $clog2(slruc_pkg::DefMaxSets);
  localparam logic [63:0] CountMax   = (64'd1 << slruc_pkg::DefCountWidth) - 64'd1;

  // The fourth command code is not in the package; the block treats it as a load.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // Register index past the last register; writes there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned SqueezeCycles = 300;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] addr;
  } access_t;

  typedef struct packed {
    logic        was_hit;
    logic        was_evicted;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
  } outcome_t;

  // Clock, reset and all block inputs start from known values.
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // tdata: address [63:0]
  logic [63:0]         s_axis_tdata  = '0;
  // tuser: cmd [1:0]
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // tdata: hit_total [31:0], miss_total [63:32], evict_total [95:64]
  logic [95:0]         m_axis_tdata;
  // tuser: was_hit [0], was_evicted [1]
  logic [1:0]          m_axis_tuser;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [slruc_pkg::ApbAddrW-1:0] paddr  = '0;
  logic [slruc_pkg::ApbDataW-1:0] pwdata = '0;
  logic [slruc_pkg::ApbDataW-1:0] prdata;
  logic                pready;

  set_assoc_lru_cache_tags dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Local cache model. The registers are kept raw, exactly as written, and the
  // effective values are derived at each access, as the block does.
  // --------------------------------------------------------------------------
  logic [2:0]  cfg_set_bits   = slruc_pkg::SetBitsRst;
  logic [4:0]  cfg_block_bits = slruc_pkg::BlockBitsRst;
  logic [3:0]  cfg_ways       = slruc_pkg::WaysRst;

  logic        tag_valid [NumSets][NumWays];
  logic [63:0] tag_store [NumSets][NumWays];
  int unsigned line_rank [NumSets][NumWays];   // 0 is the most recent line
  logic [63:0] hits, misses, evicts;

  // Requests waiting to be offered, and results predicted but not yet seen.
  access_t     access_q[$];
  outcome_t    outcome_q[$];

  int unsigned n_errors   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_settings = 1;

  // Set bits below one count as one; above what the set store holds they clip.
  function automatic int unsigned eff_set_bits();
    int unsigned s;
    s = 32'(cfg_set_bits);
    if (s < 1) s = 1;
    if (s > MaxSetBits) s = MaxSetBits;
    return s;
  endfunction

  // Zero block bits count as one so the tag never exceeds 62 bits.
  function automatic int unsigned eff_block_bits();
    return (cfg_block_bits == 5'd0) ? 1 : 32'(cfg_block_bits);
  endfunction

  // Zero ways count as one; more ways than built clip to the built count.
  function automatic int unsigned eff_ways();
    int unsigned w;
    w = 32'(cfg_ways);
    if (w < 1) w = 1;
    if (w > NumWays) w = NumWays;
    return w;
  endfunction

  function automatic logic [63:0] sat_inc(logic [63:0] cnt);
    return (cnt < CountMax) ? cnt + 64'd1 : cnt;
  endfunction

  // Make one way the most recent. Only valid lines younger than the touched
  // one age by a step, and no rank grows past the oldest possible value.
  function automatic void promote(int unsigned idx, int unsigned way, int unsigned nways);
    int unsigned old_rank;
    old_rank = tag_valid[idx][way] ? line_rank[idx][way] : NumWays;
    for (int unsigned i = 0; i < nways; i++) begin
      if (i != way && tag_valid[idx][i] && line_rank[idx][i] < old_rank &&
          line_rank[idx][i] < NumWays - 1)
        line_rank[idx][i]++;
    end
    line_rank[idx][way] = 0;
  endfunction

  // Look up one access, update the model and return the result it causes.
  function automatic outcome_t cache_access(access_t acc);
    int unsigned sb, bb, nw, idx, hit_way, empty_way, lru_way, lru_rank, way;
    logic [63:0] tag;
    logic        hit, have_empty, have_lru, evicted;
    outcome_t    res;
    sb  = eff_set_bits();
    bb  = eff_block_bits();
    nw  = eff_ways();
    idx = 32'((acc.addr >> bb) & ((64'd1 << sb) - 64'd1));
    tag = acc.addr >> (sb + bb);
    hit = 1'b0;
    have_empty = 1'b0;
    have_lru = 1'b0;
    evicted = 1'b0;
    hit_way = 0;
    empty_way = 0;
    lru_way = 0;
    lru_rank = 0;
    for (int unsigned i = 0; i < nw; i++) begin
      if (tag_valid[idx][i]) begin
        // Strictly older wins, so on a tie the lowest way stays the victim.
        if (!have_lru || line_rank[idx][i] > lru_rank) begin
          have_lru = 1'b1;
          lru_rank = line_rank[idx][i];
          lru_way  = i;
        end
        if (tag_store[idx][i] == tag) begin
          hit     = 1'b1;
          hit_way = i;
        end
      end else if (!have_empty) begin
        have_empty = 1'b1;
        empty_way  = i;
      end
    end
    if (hit) begin
      hits = sat_inc(hits);
      promote(idx, hit_way, nw);
    end else begin
      way    = have_empty ? empty_way : lru_way;
      misses = sat_inc(misses);
      if (!have_empty) begin
        evicted = 1'b1;
        evicts  = sat_inc(evicts);
      end
      promote(idx, way, nw);
      tag_store[idx][way] = tag;
      tag_valid[idx][way] = 1'b1;
    end
    // A modify is a load followed by a store that always hits.
    if (acc.cmd == slruc_pkg::CMD_MODIFY) hits = sat_inc(hits);
    res.was_hit     = hit;
    res.was_evicted = evicted;
    res.hit_total   = hits[31:0];
    res.miss_total  = misses[31:0];
    res.evict_total = evicts[31:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random request generation. Most addresses draw their tag and set from
  // small pools so that sets fill up, hit, age and evict; the rest are fully
  // random 64-bit addresses.
  // --------------------------------------------------------------------------
  logic [63:0] tag_pool[$];
  logic [63:0] set_pool[$];

  function automatic void refill_pools();
    int unsigned n_tags, n_sets;
    tag_pool.delete();
    set_pool.delete();
    n_tags = eff_ways() + $urandom_range(0, 4);
    n_sets = $urandom_range(1, 3);
    for (int unsigned i = 0; i < n_tags; i++)
      tag_pool.push_back(($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                     : 64'($urandom_range(0, 15)));
    for (int unsigned i = 0; i < n_sets; i++)
      set_pool.push_back(64'($urandom));
  endfunction

  function automatic access_t rand_access();
    access_t     acc;
    int unsigned sb, bb, pick;
    logic [63:0] tag, idx, off;
    sb   = eff_set_bits();
    bb   = eff_block_bits();
    pick = $urandom_range(0, 99);
    off  = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
    acc.cmd = 2'($urandom_range(0, 3));
    if (pick < 85) begin
      tag = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
      idx = (pick < 75) ? set_pool[$urandom_range(0, set_pool.size() - 1)] : 64'($urandom);
      acc.addr = (tag << (sb + bb)) | ((idx & ((64'd1 << sb) - 64'd1)) << bb) | off;
    end else begin
      acc.addr = {$urandom, $urandom};
    end
    return acc;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. It offers the head of access_q in bursts of random length
  // separated by random gaps, holds a request steady until it is taken, and
  // predicts the result at the edge where the request is accepted.
  // --------------------------------------------------------------------------
  access_t     cur_acc;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    logic take;
    take = s_axis_tvalid && s_axis_tready;
    if (take) begin
      outcome_q.push_back(cache_access(cur_acc));
      void'(access_q.pop_front());
      n_accepted++;
    end
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || take) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (access_q.size() > 0) begin
        cur_acc = access_q[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= access_q[0].addr;
        s_axis_tuser  <= access_q[0].cmd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // A third of the bursts run straight into the next one.
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Every accepted result is checked against the oldest
  // prediction. tready steps through an 8-bit pattern that is redrawn now and
  // then, often all ones; once, on request, it is held low for a long stretch.
  // --------------------------------------------------------------------------
  logic        squeeze_req  = 1'b0;
  logic        squeeze_done = 1'b0;
  int unsigned hold_left    = 0;
  logic [7:0]  stall_pat    = 8'hFF;
  int unsigned pat_pos      = 0;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (outcome_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        n_errors++;
      end else begin
        want = outcome_q.pop_front();
        check_field("was_hit",     32'(want.was_hit),     32'(m_axis_tuser[0]));
        check_field("was_evicted", 32'(want.was_evicted), 32'(m_axis_tuser[1]));
        check_field("hit_total",   want.hit_total,        m_axis_tdata[31:0]);
        check_field("miss_total",  want.miss_total,       m_axis_tdata[63:32]);
        check_field("evict_total", want.evict_total,      m_axis_tdata[95:64]);
      end
    end
    if (squeeze_req && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left    = SqueezeCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= stall_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 8;
      if (pat_pos == 0 && $urandom_range(0, 3) == 0)
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles without any handshake while work is outstanding.
  // The long receiver hold-off and the clearing pass after reset both fit
  // well inside the limit.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready) ||
        (access_q.size() == 0 && outcome_q.size() == 0 && !psel)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no progress for %0d cycles, %0d results outstanding",
               WatchdogLimit, outcome_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration port tasks.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] reg_mask(logic [1:0] idx);
    case (idx)
      slruc_pkg::REG_SET_BITS:   return 32'h0000_0007;
      slruc_pkg::REG_BLOCK_BITS: return 32'h0000_001F;
      slruc_pkg::REG_WAYS:       return 32'h0000_000F;
      default:                   return 32'hFFFF_FFFF;
    endcase
  endfunction

  // One transfer: a setup phase, then the access phase until pready. The model
  // takes a write at the same edge as the block.
  task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] data,
                          output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      case (idx)
        slruc_pkg::REG_SET_BITS:   cfg_set_bits   = data[2:0];
        slruc_pkg::REG_BLOCK_BITS: cfg_block_bits = data[4:0];
        slruc_pkg::REG_WAYS:       cfg_ways       = data[3:0];
        default:                   ;
      endcase
    end
  endtask

  task automatic read_check(input logic [1:0] idx);
    logic [31:0] rdata, want;
    apb_xfer(1'b0, idx, '0, rdata);
    case (idx)
      slruc_pkg::REG_SET_BITS:   want = 32'(cfg_set_bits);
      slruc_pkg::REG_BLOCK_BITS: want = 32'(cfg_block_bits);
      default:                   want = 32'(cfg_ways);
    endcase
    if ((rdata & reg_mask(idx)) !== want) begin
      $error("register %0d readback mismatch: expected %0d, got %0d",
             idx, want, rdata & reg_mask(idx));
      n_errors++;
    end
  endtask

  // Write a field value with random upper bits, then read it back.
  task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    apb_xfer(1'b1, idx, ($urandom & ~reg_mask(idx)) | (val & reg_mask(idx)), unused);
    read_check(idx);
  endtask

  // Wait until every offered request has produced its result, then a further
  // DrainCycles edges so the block is idle before the registers change.
  task automatic wait_drain();
    while (access_q.size() != 0 || outcome_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_access(input logic [1:0] cmd, input logic [63:0] addr);
    access_t acc;
    acc.cmd  = cmd;
    acc.addr = addr;
    access_q.push_back(acc);
  endtask

  // One register setting followed by a run of random requests. The cache
  // contents carry over, so a new setting also sees lines left by the last.
  task automatic run_phase(input logic [2:0] sb, input logic [4:0] bb, input logic [3:0] ways,
                           input int unsigned count);
    program_reg(slruc_pkg::REG_SET_BITS, 32'(sb));
    program_reg(slruc_pkg::REG_BLOCK_BITS, 32'(bb));
    program_reg(slruc_pkg::REG_WAYS, 32'(ways));
    n_settings++;
    refill_pools();
    for (int unsigned i = 0; i < count; i++) access_q.push_back(rand_access());
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] unused;
    for (int i = 0; i < NumSets; i++) begin
      for (int j = 0; j < NumWays; j++) begin
        tag_valid[i][j] = 1'b0;
        tag_store[i][j] = '0;
        line_rank[i][j] = 0;
      end
    end
    hits   = '0;
    misses = '0;
    evicts = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers must read back their reset values.
    read_check(slruc_pkg::REG_SET_BITS);
    read_check(slruc_pkg::REG_BLOCK_BITS);
    read_check(slruc_pkg::REG_WAYS);

    // Directed requests under the reset setting: two sets, 16-byte lines,
    // eight ways, so the set is address bit 4 and the tag starts at bit 5.
    queue_access(slruc_pkg::CMD_LOAD,   64'h0);                    // cold miss
    queue_access(slruc_pkg::CMD_STORE,  64'h0);                    // hit on the same line
    queue_access(slruc_pkg::CMD_MODIFY, 64'h0);                    // hit plus the extra hit
    queue_access(CMD_SPARE,             64'hFFFF_FFFF_FFFF_FFFF);  // unused code acts as a load
    queue_access(slruc_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_access(slruc_pkg::CMD_STORE,  64'h8000_0000_0000_0000);
    // Fill set 0 past its eight ways so the oldest line is replaced.
    for (int unsigned t = 1; t <= 7; t++) queue_access(slruc_pkg::CMD_LOAD, 64'(t) << 5);
    queue_access(slruc_pkg::CMD_LOAD,   64'h0000_0000_0000_000F);  // evicted line returns
    queue_access(slruc_pkg::CMD_MODIFY, 64'h5555_5555_5555_5555);
    queue_access(slruc_pkg::CMD_STORE,  64'hAAAA_AAAA_AAAA_AAAA);
    queue_access(slruc_pkg::CMD_LOAD,   64'h0000_0000_0000_0010);
    queue_access(slruc_pkg::CMD_MODIFY, 64'h8000_0000_0000_0000);
    wait_drain();

    // Largest legal set and way counts.
    run_phase(3'd6, 5'd16, 4'd8, 130);
    // A write past the last register must leave the setting alone.
    apb_xfer(1'b1, REG_SPARE, $urandom, unused);
    // Smallest legal geometry: a direct-mapped cache.
    run_phase(3'd1, 5'd1, 4'd1, 120);
    // All-zero fields fall back to their minimum effective values.
    run_phase(3'd0, 5'd0, 4'd0, 120);
    // All-ones fields clip to the largest effective values.
    run_phase(3'd7, 5'd31, 4'd15, 120);

    // Hold the result side off for a long stretch while requests keep
    // coming, so the block fills and back-pressures its input. The sender
    // then pauses until everything has drained before the second half.
    squeeze_req = 1'b1;
    run_phase(3'd3, 5'd5, 4'd4, 150);
    run_phase(3'd3, 5'd5, 4'd4, 150);

    // Random settings over the whole range of each field.
    for (int unsigned p = 0; p < 4; p++)
      run_phase(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                4'($urandom_range(0, 15)), 110);

    wait_drain();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d results for %0d requests across %0d register settings.",
             n_results, n_accepted, n_settings);
    $display("Model totals: %0d hits, %0d misses, %0d evictions.", hits, misses, evicts);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
